@@ rtl/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int unsigned DefaultColumns = 80;
  localparam int unsigned DefaultRows    = 25;

  localparam logic [15:0] BlankCell   = 16'h0720;
  localparam logic [7:0]  AttrReset   = 8'h07;
  localparam logic [7:0]  ChNewline   = 8'd10;
  localparam logic [7:0]  ChReturn    = 8'd13;
  localparam logic [7:0]  ChBackspace = 8'd8;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } rsp_t;

  typedef enum logic [1:0] {
    KindNewline,
    KindReturn,
    KindBackspace,
    KindPrint
  } char_kind_e;

  typedef enum logic [1:0] {
    ColHold,
    ColZero,
    ColInc,
    ColDec
  } col_op_e;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    logic    mem_we;
    logic    wsel_char;
    col_op_e col_op;
    logic    row_step;
    logic    clr_en;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       is_read;
    logic       in_range;
    char_kind_e kind;
    logic       at_col0;
    logic       at_last_col;
    logic       at_last_row;
    logic       clr_done;
    logic       out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
// Datapath: screen memory, cursor, scroll offset, clear counter and result register.
`default_nettype none

module tcw_datapath #(
  parameter int unsigned COLUMNS = tcw_pkg::DefaultColumns,
  parameter int unsigned ROWS    = tcw_pkg::DefaultRows
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire tcw_pkg::req_t          in_data_i,
  input  wire                         cfg_valid_i,
  input  wire  [7:0]                  cfg_data_i,
  input  wire                         out_ready_i,
  input  wire tcw_pkg::ctrl_cmd_t     cmd_i,
  output tcw_pkg::ctrl_status_t       status_o,
  output logic                        out_valid_o,
  output tcw_pkg::rsp_t               out_data_o
);

  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ColW  = $clog2(COLUMNS);
  localparam int unsigned AddrW = $clog2(Cells);

  logic [15:0]      mem_q [Cells];
  logic [15:0]      rd_q;
  tcw_pkg::req_t    req_q;
  logic [RowW-1:0]  row_q, top_q;
  logic [ColW-1:0]  col_q;
  logic [7:0]       attr_q;
  logic [AddrW-1:0] clr_addr_q, clr_last_q;
  logic             out_valid_q;
  tcw_pkg::rsp_t    out_q;

  logic [AddrW-1:0] wr_addr, rd_addr, top_base;
  logic [ColW-1:0]  wr_col;
  logic [15:0]      wr_data;
  logic             wr_en;
  logic [RowW-1:0]  top_next;

  // Logical row plus the scroll offset, folded back into the physical row range.
  function automatic logic [AddrW-1:0] cell_addr(logic [RowW-1:0] row, logic [ColW-1:0] col,
                                                 logic [RowW-1:0] top);
    logic [RowW:0] sum;
    logic [RowW:0] phys;
    sum  = {1'b0, row} + {1'b0, top};
    phys = (sum >= (RowW+1)'(ROWS)) ? sum - (RowW+1)'(ROWS) : sum;
    return AddrW'(phys * COLUMNS) + AddrW'(col);
  endfunction

  assign wr_col   = (cmd_i.col_op == tcw_pkg::ColDec) ? col_q - ColW'(1) : col_q;
  assign wr_addr  = cmd_i.clr_en ? clr_addr_q : cell_addr(row_q, wr_col, top_q);
  assign wr_data  = (cmd_i.mem_we && cmd_i.wsel_char) ? {attr_q, req_q.char_code}
                                                      : tcw_pkg::BlankCell;
  assign wr_en    = cmd_i.mem_we | cmd_i.clr_en;
  assign rd_addr  = cell_addr(RowW'(req_q.cell_row), ColW'(req_q.cell_col), top_q);
  assign top_base = AddrW'(top_q * COLUMNS);
  assign top_next = (top_q == RowW'(ROWS - 1)) ? '0 : top_q + RowW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
    if (cmd_i.latch) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      top_q       <= '0;
      attr_q      <= tcw_pkg::AttrReset;
      clr_addr_q  <= '0;
      clr_last_q  <= AddrW'(Cells - 1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
      unique case (cmd_i.col_op)
        tcw_pkg::ColHold: col_q <= col_q;
        tcw_pkg::ColZero: col_q <= '0;
        tcw_pkg::ColInc:  col_q <= col_q + ColW'(1);
        tcw_pkg::ColDec:  col_q <= col_q - ColW'(1);
        default:          col_q <= col_q;
      endcase
      if (cmd_i.row_step) begin
        if (row_q == RowW'(ROWS - 1)) begin
          // The old top row becomes the new bottom row and is blanked next.
          top_q      <= top_next;
          clr_addr_q <= top_base;
          clr_last_q <= top_base + AddrW'(COLUMNS - 1);
        end else begin
          row_q <= row_q + RowW'(1);
        end
      end else if (cmd_i.clr_en) begin
        clr_addr_q <= clr_addr_q + AddrW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.cell_value <= (req_q.req_type && status_o.in_range) ? rd_q : 16'h0000;
      out_q.cursor_row <= 5'(row_q);
      out_q.cursor_col <= 7'(col_q);
    end
  end

  always_comb begin
    status_o.is_read  = req_q.req_type;
    status_o.in_range = (int'(req_q.cell_row) < ROWS) && (int'(req_q.cell_col) < COLUMNS);
    unique case (req_q.char_code)
      tcw_pkg::ChNewline:   status_o.kind = tcw_pkg::KindNewline;
      tcw_pkg::ChReturn:    status_o.kind = tcw_pkg::KindReturn;
      tcw_pkg::ChBackspace: status_o.kind = tcw_pkg::KindBackspace;
      default:              status_o.kind = tcw_pkg::KindPrint;
    endcase
    status_o.at_col0     = (col_q == '0);
    status_o.at_last_col = (col_q == ColW'(COLUMNS - 1));
    status_o.at_last_row = (row_q == RowW'(ROWS - 1));
    status_o.clr_done    = (clr_addr_q == clr_last_q);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// Controller state machine: sequences the clear sweep, requests, scrolls and result hand-off.
`default_nettype none

module tcw_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire tcw_pkg::ctrl_status_t  status_i,
  output tcw_pkg::ctrl_cmd_t          cmd_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDecode,
    StScroll,
    StDone
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StDecode;
        end
      end
      StDecode: begin
        state_d = StDone;
        if (status_i.is_read) begin
          cmd_o.rd_en = status_i.in_range;
        end else begin
          unique case (status_i.kind)
            tcw_pkg::KindNewline: begin
              cmd_o.col_op   = tcw_pkg::ColZero;
              cmd_o.row_step = 1'b1;
              if (status_i.at_last_row) begin
                state_d = StScroll;
              end
            end
            tcw_pkg::KindReturn: begin
              cmd_o.col_op = tcw_pkg::ColZero;
            end
            tcw_pkg::KindBackspace: begin
              if (!status_i.at_col0) begin
                cmd_o.col_op = tcw_pkg::ColDec;
                cmd_o.mem_we = 1'b1;
              end
            end
            tcw_pkg::KindPrint: begin
              cmd_o.mem_we    = 1'b1;
              cmd_o.wsel_char = 1'b1;
              if (status_i.at_last_col) begin
                cmd_o.col_op   = tcw_pkg::ColZero;
                cmd_o.row_step = 1'b1;
                if (status_i.at_last_row) begin
                  state_d = StScroll;
                end
              end else begin
                cmd_o.col_op = tcw_pkg::ColInc;
              end
            end
            default: begin
              cmd_o.col_op = tcw_pkg::ColHold;
            end
          endcase
        end
      end
      StScroll: begin
        cmd_o.clr_en = 1'b1;
        if (status_i.clr_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Text console writer top level: one request per input beat, one result beat per request.
// A read or an ordinary put steps through the decode and done states before its result beat
// is offered; a put that scrolls also blanks the recycled bottom row in a scroll state between.
// A new input beat is taken only once the last result beat is loaded, so a held result
// beat holds off the next input beat. Scrolling moves a row offset instead of copying memory.
// Reset: a sweep blanks all ROWS*COLUMNS cells, one per cycle, before the first input beat.
`default_nettype none

module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::DefaultColumns,
  parameter int unsigned ROWS    = tcw_pkg::DefaultRows
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire tcw_pkg::req_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output tcw_pkg::rsp_t       out_data_o,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [7:0]          cfg_data_i
);

  tcw_pkg::ctrl_cmd_t    cmd;
  tcw_pkg::ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
